// ===== sv/i2c_rtc_transaction_sequencer_macros.svh =====
// shared assertion macros for the rtc sequencer checker
`ifndef I2C_RTC_TRANSACTION_SEQUENCER_MACROS_SVH
`define I2C_RTC_TRANSACTION_SEQUENCER_MACROS_SVH

// same-cycle implication, sampled on the rising clock, quiet during reset
`define RTCS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on the rising clock, quiet during reset
`define RTCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rtcs_pkg.sv =====
`timescale 1ns / 1ps

package rtcs_pkg;

  // stream word widths and device address width
  localparam int unsigned InTdataW  = 40;
  localparam int unsigned OutTdataW = 40;
  localparam int unsigned AddrW     = 7;

  localparam logic [AddrW-1:0] DevAddrReset = 7'd104;

  // clock chip register pointers and data
  localparam logic [7:0] RegTime     = 8'h00;
  localparam logic [7:0] RegAlarm    = 8'h07;
  localparam logic [7:0] RegControl  = 8'h0E;
  localparam logic [7:0] RegStatus   = 8'h0F;
  localparam logic [7:0] CtrlValue   = 8'b00000101;
  localparam logic [7:0] StatusClear = 8'h00;

  // bus commands
  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_SEND    = 3'd2,
    CMD_RX_ACK  = 3'd3,
    CMD_RX_NACK = 3'd4,
    CMD_STOP    = 3'd5
  } cmd_e;

  // operation kinds, control write is the chained alarm transaction
  typedef enum logic [2:0] {
    OP_READ  = 3'd0,
    OP_WRITE = 3'd1,
    OP_ALARM = 3'd2,
    OP_CLEAR = 3'd3,
    OP_CTRL  = 3'd4,
    OP_NONE  = 3'd5
  } op_e;

  // sequence steps, one-hot
  typedef enum logic [19:0] {
    ST_IDLE     = 20'h00001,
    ST_START    = 20'h00002,
    ST_ADDR     = 20'h00004,
    ST_PTR_READ = 20'h00008,
    ST_RESTART  = 20'h00010,
    ST_RADDR    = 20'h00020,
    ST_RSEC     = 20'h00040,
    ST_RMIN     = 20'h00080,
    ST_RHOUR    = 20'h00100,
    ST_WSEC     = 20'h00200,
    ST_WMIN     = 20'h00400,
    ST_WHOUR    = 20'h00800,
    ST_ASEC     = 20'h01000,
    ST_AMIN     = 20'h02000,
    ST_AHOUR    = 20'h04000,
    ST_ACHAIN   = 20'h08000,
    ST_CLR      = 20'h10000,
    ST_CTRL     = 20'h20000,
    ST_CTRL_VAL = 20'h40000,
    ST_FINISH   = 20'h80000
  } step_e;

  // one input word, unpacked
  typedef struct packed {
    logic       req_type;
    logic [1:0] operation;
    logic [7:0] set_seconds;
    logic [7:0] set_minutes;
    logic [7:0] set_hours;
    logic [7:0] bus_rx_byte;
  } item_t;

  // one result word, unpacked
  typedef struct packed {
    cmd_e       bus_command;
    logic [7:0] send_byte;
    logic [7:0] rtc_sec;
    logic [7:0] rtc_min;
    logic [7:0] rtc_hour;
    logic       op_done;
    logic       busy_res;
  } result_t;

endpackage

// ===== sv/rtcs_fsm.sv =====
`timescale 1ns / 1ps

module rtcs_fsm (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_en_i,
  input  rtcs_pkg::item_t           item_i,
  input  logic [rtcs_pkg::AddrW-1:0] dev_addr_i,
  output rtcs_pkg::result_t         result_o
);
  import rtcs_pkg::*;

  step_e      step_q, step_d;
  op_e        op_q, op_d;
  logic [7:0] pend_sec_q, pend_sec_d;
  logic [7:0] pend_min_q, pend_min_d;
  logic [7:0] pend_hour_q, pend_hour_d;
  logic [7:0] capt_sec_q, capt_sec_d;
  logic [7:0] capt_min_q, capt_min_d;
  logic [7:0] capt_hour_q, capt_hour_d;
  cmd_e       cmd;
  logic [7:0] tx;
  logic       done;
  logic [7:0] waddr;

  assign waddr = {dev_addr_i, 1'b0};

  // next step and bus command for the word at the input register
  always_comb begin
    step_d      = step_q;
    op_d        = op_q;
    pend_sec_d  = pend_sec_q;
    pend_min_d  = pend_min_q;
    pend_hour_d = pend_hour_q;
    capt_sec_d  = capt_sec_q;
    capt_min_d  = capt_min_q;
    capt_hour_d = capt_hour_q;
    cmd         = CMD_NONE;
    tx          = 8'h00;
    done        = 1'b0;
    if (!item_i.req_type) begin
      // start request, dropped while an operation runs
      if (step_q == ST_IDLE) begin
        op_d        = op_e'({1'b0, item_i.operation});
        pend_sec_d  = item_i.set_seconds;
        pend_min_d  = item_i.set_minutes;
        pend_hour_d = item_i.set_hours;
        cmd         = CMD_START;
        step_d      = ST_START;
      end
    end else begin
      case (step_q)
        ST_START: begin
          cmd    = CMD_SEND;
          tx     = waddr;
          step_d = ST_ADDR;
        end
        ST_ADDR: begin
          cmd = CMD_SEND;
          case (op_q)
            OP_READ: begin
              tx     = RegTime;
              step_d = ST_PTR_READ;
            end
            OP_WRITE: begin
              tx     = RegTime;
              step_d = ST_WSEC;
            end
            OP_ALARM: begin
              tx     = RegAlarm;
              step_d = ST_ASEC;
            end
            OP_CLEAR: begin
              tx     = RegStatus;
              step_d = ST_CLR;
            end
            OP_CTRL: begin
              tx     = RegControl;
              step_d = ST_CTRL;
            end
            default: begin
              cmd    = CMD_STOP;
              done   = 1'b1;
              step_d = ST_IDLE;
              op_d   = OP_NONE;
            end
          endcase
        end
        ST_PTR_READ: begin
          cmd    = CMD_START;
          step_d = ST_RESTART;
        end
        ST_RESTART: begin
          cmd    = CMD_SEND;
          tx     = waddr | 8'h01;
          step_d = ST_RADDR;
        end
        ST_RADDR: begin
          cmd    = CMD_RX_ACK;
          step_d = ST_RSEC;
        end
        ST_RSEC: begin
          capt_sec_d = item_i.bus_rx_byte;
          cmd        = CMD_RX_ACK;
          step_d     = ST_RMIN;
        end
        ST_RMIN: begin
          capt_min_d = item_i.bus_rx_byte;
          cmd        = CMD_RX_NACK;
          step_d     = ST_RHOUR;
        end
        ST_RHOUR: begin
          capt_hour_d = item_i.bus_rx_byte;
          cmd         = CMD_STOP;
          done        = 1'b1;
          step_d      = ST_IDLE;
          op_d        = OP_NONE;
        end
        ST_WSEC: begin
          cmd    = CMD_SEND;
          tx     = pend_sec_q;
          step_d = ST_WMIN;
        end
        ST_ASEC: begin
          cmd    = CMD_SEND;
          tx     = pend_sec_q;
          step_d = ST_AMIN;
        end
        ST_WMIN: begin
          cmd    = CMD_SEND;
          tx     = pend_min_q;
          step_d = ST_WHOUR;
        end
        ST_AMIN: begin
          cmd    = CMD_SEND;
          tx     = pend_min_q;
          step_d = ST_AHOUR;
        end
        ST_WHOUR: begin
          cmd    = CMD_SEND;
          tx     = pend_hour_q;
          step_d = ST_FINISH;
        end
        ST_AHOUR: begin
          cmd    = CMD_SEND;
          tx     = pend_hour_q;
          step_d = ST_ACHAIN;
        end
        // alarm set, chain the control register write
        ST_ACHAIN: begin
          cmd    = CMD_START;
          op_d   = OP_CTRL;
          step_d = ST_START;
        end
        ST_CLR: begin
          cmd    = CMD_SEND;
          tx     = StatusClear;
          step_d = ST_FINISH;
        end
        ST_CTRL: begin
          cmd    = CMD_SEND;
          tx     = CtrlValue;
          step_d = ST_CTRL_VAL;
        end
        ST_CTRL_VAL, ST_FINISH: begin
          cmd    = CMD_STOP;
          done   = 1'b1;
          step_d = ST_IDLE;
          op_d   = OP_NONE;
        end
        default: begin
          step_d = ST_IDLE;
        end
      endcase
    end
  end

  // result seen after this word
  assign result_o.bus_command = cmd;
  assign result_o.send_byte   = tx;
  assign result_o.rtc_sec     = capt_sec_d;
  assign result_o.rtc_min     = capt_min_d;
  assign result_o.rtc_hour    = capt_hour_d;
  assign result_o.op_done     = done;
  assign result_o.busy_res    = (step_d != ST_IDLE);

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_IDLE;
      op_q        <= OP_NONE;
      pend_sec_q  <= 8'h00;
      pend_min_q  <= 8'h00;
      pend_hour_q <= 8'h00;
      capt_sec_q  <= 8'h00;
      capt_min_q  <= 8'h00;
      capt_hour_q <= 8'h00;
    end else if (step_en_i) begin
      step_q      <= step_d;
      op_q        <= op_d;
      pend_sec_q  <= pend_sec_d;
      pend_min_q  <= pend_min_d;
      pend_hour_q <= pend_hour_d;
      capt_sec_q  <= capt_sec_d;
      capt_min_q  <= capt_min_d;
      capt_hour_q <= capt_hour_d;
    end
  end

endmodule

// ===== sv/i2c_rtc_transaction_sequencer.sv =====
`timescale 1ns / 1ps

// Bus transaction sequencer for a real-time clock chip. Each input word is
// either a start request (operation and three time bytes) or a bus completion
// event (with the received byte); each word gives exactly one result word with
// the next bus command, the byte to send, the last time bytes read, an end of
// operation mark on tlast and a busy flag. One word is taken per clock cycle
// while the result word is not stalled by m_axis_tready; each word passes
// through the input register, then its result word through the result
// register. The sequence step register updates with each word that advances.
// Write the device address only while no word is in flight; it resets to 104.
module i2c_rtc_transaction_sequencer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rtcs_pkg::AddrW-1:0]       cfg_wdata_i,    // device_address
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // operation, set_seconds, set_minutes, set_hours, bus_rx_byte, zero fill
  input  logic [rtcs_pkg::InTdataW-1:0]    s_axis_tdata,
  input  logic                             s_axis_tuser,   // req_type
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // send_byte, rtc_sec, rtc_min, rtc_hour, busy_res, zero fill
  output logic [rtcs_pkg::OutTdataW-1:0]   m_axis_tdata,
  output logic [2:0]                       m_axis_tuser,   // bus_command
  output logic                             m_axis_tlast    // op_done
);
  import rtcs_pkg::*;

  logic [AddrW-1:0] dev_addr_q;
  logic             in_valid_q;
  item_t            in_item_q;
  item_t            s_item;
  logic             out_valid_q;
  result_t          out_res_q;
  result_t          step_res;
  logic             out_ready;
  logic             advance;
  logic             in_accept;

  // device address register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= DevAddrReset;
    end else if (cfg_we_i) begin
      dev_addr_q <= cfg_wdata_i;
    end
  end

  // handshake between input register and result register
  assign out_ready     = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // unpack the input word
  assign s_item.req_type    = s_axis_tuser;
  assign s_item.operation   = s_axis_tdata[1:0];
  assign s_item.set_seconds = s_axis_tdata[9:2];
  assign s_item.set_minutes = s_axis_tdata[17:10];
  assign s_item.set_hours   = s_axis_tdata[25:18];
  assign s_item.bus_rx_byte = s_axis_tdata[33:26];

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q <= s_item;
    end
  end

  // sequencer step logic and state
  rtcs_fsm u_fsm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_en_i  (advance),
    .item_i     (in_item_q),
    .dev_addr_i (dev_addr_q),
    .result_o   (step_res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= step_res;
    end
  end

  // pack the result word
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.bus_command;
  assign m_axis_tlast  = out_res_q.op_done;
  assign m_axis_tdata  = {7'b0, out_res_q.busy_res, out_res_q.rtc_hour,
                          out_res_q.rtc_min, out_res_q.rtc_sec,
                          out_res_q.send_byte};

endmodule

// ===== sv/rtcs_checker.sv =====
`timescale 1ns / 1ps
`include "i2c_rtc_transaction_sequencer_macros.svh"

module rtcs_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [rtcs_pkg::OutTdataW-1:0] m_axis_tdata,
  input logic [2:0]                     m_axis_tuser,
  input logic                           m_axis_tlast
);
  import rtcs_pkg::*;

  // end of operation is always a stop that leaves the block idle
  `RTCS_ASSERT_NOW(a_done_is_stop, m_axis_tvalid && m_axis_tlast, (m_axis_tuser == CMD_STOP) && !m_axis_tdata[32], "op_done without a final stop")

  // a byte to send only goes with a send command
  `RTCS_ASSERT_NOW(a_tx_only_on_send, m_axis_tvalid && (m_axis_tuser != CMD_SEND), m_axis_tdata[7:0] == 8'h00, "send_byte set on a non-send command")

  // the nack read is never the last step of an operation
  `RTCS_ASSERT_NOW(a_nack_busy, m_axis_tvalid && (m_axis_tuser == CMD_RX_NACK), m_axis_tdata[32] && !m_axis_tlast, "nack read without busy")

  // a stalled result word holds
  `RTCS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result word changed while stalled")

endmodule

bind i2c_rtc_transaction_sequencer rtcs_checker u_rtcs_checker (.*);
